>>> hw/rtl/ldr_light_level_classifier_top_assert.svh
// Assertion macros for the light level classifier.
// Used by the top level; depends on nothing else.
`ifndef LDR_LIGHT_LEVEL_CLASSIFIER_TOP_ASSERT_SVH
`define LDR_LIGHT_LEVEL_CLASSIFIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LDRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ldrc assertion failed");
`define LDRC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ldrc assertion failed");
`else
`define LDRC_ASSERT(lbl, clk, rst_n, prop)
`define LDRC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> hw/rtl/ldrc_pkg.sv
// Shared types and constants of the light level classifier.
// Used by the interfaces, the lanes, the merge stage and the top level.
package ldrc_pkg;
    localparam int unsigned LANES = 4;
    localparam int unsigned SW = 12;
    localparam int unsigned RW = 16;
    localparam int unsigned PW = SW + RW;
    localparam int unsigned IDXW = 4;
    localparam logic [SW-1:0] ADC_FULL = 12'd4095;
    localparam logic [RW-1:0] R_MAX = 16'hFFFF;

    localparam logic [IDXW-1:0] IDX_DIVR0 = 4'd0;
    localparam logic [IDXW-1:0] IDX_DIVR1 = 4'd1;
    localparam logic [IDXW-1:0] IDX_DIVR2 = 4'd2;
    localparam logic [IDXW-1:0] IDX_DIVR3 = 4'd3;
    localparam logic [IDXW-1:0] IDX_DARK = 4'd4;
    localparam logic [IDXW-1:0] IDX_INDOOR = 4'd5;
    localparam logic [IDXW-1:0] IDX_SHADE = 4'd6;
    localparam logic [IDXW-1:0] IDX_SUN = 4'd7;

    localparam logic [2:0] LVL_NIGHT = 3'd0;
    localparam logic [2:0] LVL_INDOOR = 3'd1;
    localparam logic [2:0] LVL_SHADE = 3'd2;
    localparam logic [2:0] LVL_MSUN = 3'd3;
    localparam logic [2:0] LVL_FSUN = 3'd4;

    typedef struct packed {
        logic [RW-1:0] res;
        logic          clip;
    } lane_res_t;
endpackage

>>> hw/rtl/ldrc_in_if.sv
// Input channel carrying one set of four ADC samples.
// Depends on ldrc_pkg.
interface ldrc_in_if import ldrc_pkg::*;;
    logic          valid;
    logic          ready;
    logic [SW-1:0] sample_ch0;
    logic [SW-1:0] sample_ch1;
    logic [SW-1:0] sample_ch2;
    logic [SW-1:0] sample_ch3;
    modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    input ready);
    modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  output ready);
endinterface

>>> hw/rtl/ldrc_out_if.sv
// Output channel carrying one classification result.
// Depends on ldrc_pkg.
interface ldrc_out_if import ldrc_pkg::*;;
    logic          valid;
    logic          ready;
    logic [2:0]    light_level;
    logic [RW-1:0] avg_resistance;
    logic          saturated;
    modport source (output valid, light_level, avg_resistance, saturated, input ready);
    modport sink (input valid, light_level, avg_resistance, saturated, output ready);
endinterface

>>> hw/rtl/ldrc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on ldrc_pkg.
interface ldrc_cfg_if import ldrc_pkg::*;;
    logic            valid;
    logic            ready;
    logic [IDXW-1:0] index;
    logic [RW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ldr_light_level_classifier_top.sv
// Light level classifier top: four divider lanes, merge stage, configuration registers.
// The product register loads at the accepting edge, sixteen divider stages follow, and the
// output register of the merge stage holds the result.
// Throughput is one item per cycle; the whole pipeline holds while a result waits.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// Depends on ldrc_pkg, the channel interfaces, ldrc_lane and ldrc_merge.
`include "ldr_light_level_classifier_top_assert.svh"
module ldr_light_level_classifier_top import ldrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ldrc_in_if.sink    in_ch,
    ldrc_out_if.source out_ch,
    ldrc_cfg_if.sink   cfg
);
    localparam int unsigned LAT = RW + 1;

    logic [RW-1:0] divr_reg [LANES];
    logic [RW-1:0] dark_reg;
    logic [RW-1:0] indoor_reg;
    logic [RW-1:0] shade_reg;
    logic [RW-1:0] sun_reg;
    logic [LAT-1:0] vld_reg;
    logic           out_valid_reg;
    logic           en;
    logic [SW-1:0]  samples [LANES];
    lane_res_t      lane_res [LANES];

    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;

    assign samples[0] = in_ch.sample_ch0;
    assign samples[1] = in_ch.sample_ch1;
    assign samples[2] = in_ch.sample_ch2;
    assign samples[3] = in_ch.sample_ch3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                divr_reg[i] <= 16'd490;
            end
            dark_reg <= 16'd10000;
            indoor_reg <= 16'd1000;
            shade_reg <= 16'd300;
            sun_reg <= 16'd100;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                IDX_DIVR0: divr_reg[0] <= cfg.data;
                IDX_DIVR1: divr_reg[1] <= cfg.data;
                IDX_DIVR2: divr_reg[2] <= cfg.data;
                IDX_DIVR3: divr_reg[3] <= cfg.data;
                IDX_DARK: dark_reg <= cfg.data;
                IDX_INDOOR: indoor_reg <= cfg.data;
                IDX_SHADE: shade_reg <= cfg.data;
                IDX_SUN: sun_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        ldrc_lane u_lane (
            .clk    (clk),
            .en     (en),
            .sample (samples[l]),
            .divr   (divr_reg[l]),
            .result (lane_res[l])
        );
    end

    ldrc_merge u_merge (
        .clk            (clk),
        .en             (en),
        .lane           (lane_res),
        .thr_dark       (dark_reg),
        .thr_indoor     (indoor_reg),
        .thr_shade      (shade_reg),
        .thr_sun        (sun_reg),
        .light_level    (out_ch.light_level),
        .avg_resistance (out_ch.avg_resistance),
        .saturated      (out_ch.saturated)
    );

    `LDRC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, vld_reg[0])
    `LDRC_ASSERT_NEXT(a_drain_to_out, clk, rst_n, en && vld_reg[LAT-1], out_valid_reg)
    `LDRC_ASSERT(a_level_range, clk, rst_n, out_ch.valid |-> (out_ch.light_level <= LVL_FSUN))
endmodule

>>> hw/rtl/ldrc_lane.sv
// One channel lane: multiply, then a pipelined restoring divider, one bit a stage.
// Depends on ldrc_pkg.
module ldrc_lane import ldrc_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] sample,
    input  logic [RW-1:0] divr,
    output lane_res_t     result
);
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] dvs_reg;
    logic          full_reg;

    logic [SW-1:0] rem_reg [RW];
    logic [RW-1:0] low_reg [RW];
    logic [RW-1:0] q_reg [RW];
    logic [SW-1:0] d_reg [RW];
    logic          sat_reg [RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {{RW{1'b0}}, sample} * {{SW{1'b0}}, divr};
            dvs_reg <= ADC_FULL - sample;
            full_reg <= (sample == ADC_FULL);
        end
    end

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [SW-1:0] in_rem;
        logic [RW-1:0] in_low;
        logic [RW-1:0] in_q;
        logic [SW-1:0] in_d;
        logic          in_sat;
        logic [SW:0]   trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                in_rem = prod_reg[PW-1:RW];
                in_low = prod_reg[RW-1:0];
                in_q = '0;
                in_d = dvs_reg;
                in_sat = full_reg || (prod_reg[PW-1:RW] >= dvs_reg);
            end
        end
        else
        begin : g_next
            always_comb
            begin
                in_rem = rem_reg[i-1];
                in_low = low_reg[i-1];
                in_q = q_reg[i-1];
                in_d = d_reg[i-1];
                in_sat = sat_reg[i-1];
            end
        end

        assign trial = {in_rem, in_low[RW-1]};
        assign ge = (trial >= {1'b0, in_d});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? SW'(trial - {1'b0, in_d}) : trial[SW-1:0];
                low_reg[i] <= {in_low[RW-2:0], 1'b0};
                q_reg[i] <= {in_q[RW-2:0], ge};
                d_reg[i] <= in_d;
                sat_reg[i] <= in_sat;
            end
        end
    end

    assign result.res = sat_reg[RW-1] ? R_MAX : q_reg[RW-1];
    assign result.clip = sat_reg[RW-1];
endmodule

>>> hw/rtl/ldrc_merge.sv
// Merge stage: averages the lane resistances and classifies the average.
// Depends on ldrc_pkg; holds the output register.
module ldrc_merge import ldrc_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  lane_res_t     lane [LANES],
    input  logic [RW-1:0] thr_dark,
    input  logic [RW-1:0] thr_indoor,
    input  logic [RW-1:0] thr_shade,
    input  logic [RW-1:0] thr_sun,
    output logic [2:0]    light_level,
    output logic [RW-1:0] avg_resistance,
    output logic          saturated
);
    logic [RW+1:0] sum;
    logic [RW-1:0] avg;
    logic          clip;
    logic [2:0]    level;
    logic [2:0]    level_reg;
    logic [RW-1:0] avg_reg;
    logic          sat_reg;

    always_comb
    begin
        sum = '0;
        clip = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            sum = sum + {2'b00, lane[i].res};
            clip = clip | lane[i].clip;
        end
        avg = sum[RW+1:2];
        priority if (avg >= thr_dark)
            level = LVL_NIGHT;
        else if (avg >= thr_indoor)
            level = LVL_INDOOR;
        else if (avg >= thr_shade)
            level = LVL_SHADE;
        else if (avg >= thr_sun)
            level = LVL_MSUN;
        else
            level = LVL_FSUN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= level;
            avg_reg <= avg;
            sat_reg <= clip;
        end
    end

    assign light_level = level_reg;
    assign avg_resistance = avg_reg;
    assign saturated = sat_reg;
endmodule

>>> verif/ldrc_tb_pkg.sv
// Shared helpers for the light level classifier testbench: the result record type.
// Depends on ldrc_pkg.
package ldrc_tb_pkg;
    import ldrc_pkg::*;

    typedef struct packed {
        logic [2:0]    level;
        logic [RW-1:0] avg;
        logic          sat;
    } ldrc_result_t;
endpackage

>>> verif/ldr_light_level_classifier_top_tb.sv
// Testbench for the light level classifier: directed table and random sample sets,
// checked against the table's expected values or a built-in predictor, with random idling and configuration phases.
// Depends on ldrc_pkg, ldrc_tb_pkg, the channel interfaces and the top level.
module ldr_light_level_classifier_top_tb;
    import ldrc_pkg::*;
    import ldrc_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [SW-1:0] s0;
        logic [SW-1:0] s1;
        logic [SW-1:0] s2;
        logic [SW-1:0] s3;
        bit            known;
        ldrc_result_t  res;
    } sample_row_t;

    logic clk;
    logic rst_n;

    ldrc_in_if  in_ch();
    ldrc_out_if out_ch();
    ldrc_cfg_if cfg();

    ldr_light_level_classifier_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    logic [RW-1:0] divider_ohms [LANES];
    logic [RW-1:0] thr_dark;
    logic [RW-1:0] thr_indoor;
    logic [RW-1:0] thr_shade;
    logic [RW-1:0] thr_sun;

    ldrc_result_t expected_results [$];
    int  mismatch_count;
    int  idle_cycles;
    bit  sink_idle_enable;
    bit  long_hold;
    bit  stim_done;
    bit  finished;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ldrc_result_t classify(input logic [SW-1:0] s0, input logic [SW-1:0] s1,
                                             input logic [SW-1:0] s2, input logic [SW-1:0] s3);
        logic [SW-1:0] smp [LANES];
        logic [47:0]   q;
        logic [17:0]   sum;
        logic [RW-1:0] avg;
        ldrc_result_t  r;
        smp[0] = s0;
        smp[1] = s1;
        smp[2] = s2;
        smp[3] = s3;
        sum = '0;
        r.sat = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (smp[i] == ADC_FULL)
            begin
                r.sat = 1'b1;
                sum += R_MAX;
            end
            else
            begin
                q = (48'(smp[i]) * 48'(divider_ohms[i])) / 48'(ADC_FULL - smp[i]);
                if (q > 48'(R_MAX))
                begin
                    r.sat = 1'b1;
                    sum += R_MAX;
                end
                else
                begin
                    sum += q[17:0];
                end
            end
        end
        avg = sum[17:2];
        r.avg = avg;
        if (avg >= thr_dark)
            r.level = LVL_NIGHT;
        else if (avg >= thr_indoor)
            r.level = LVL_INDOOR;
        else if (avg >= thr_shade)
            r.level = LVL_SHADE;
        else if (avg >= thr_sun)
            r.level = LVL_MSUN;
        else
            r.level = LVL_FSUN;
        return r;
    endfunction

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [RW-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            IDX_DIVR0:  divider_ohms[0] = value;
            IDX_DIVR1:  divider_ohms[1] = value;
            IDX_DIVR2:  divider_ohms[2] = value;
            IDX_DIVR3:  divider_ohms[3] = value;
            IDX_DARK:   thr_dark = value;
            IDX_INDOOR: thr_indoor = value;
            IDX_SHADE:  thr_shade = value;
            IDX_SUN:    thr_sun = value;
            default:    ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_set(input logic [SW-1:0] s0, input logic [SW-1:0] s1,
                            input logic [SW-1:0] s2, input logic [SW-1:0] s3,
                            input bit known, input ldrc_result_t typed);
        ldrc_result_t r;
        int gap;
        if (sink_idle_enable && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample_ch0 <= s0;
        in_ch.sample_ch1 <= s1;
        in_ch.sample_ch2 <= s2;
        in_ch.sample_ch3 <= s3;
        r = known ? typed : classify(s0, s1, s2, s3);
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(r);
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return SW'($urandom_range(4000, 4095));
            1: return SW'($urandom_range(0, 200));
            2: return ADC_FULL;
            default: return SW'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic random_config(input int kind);
        logic [RW-1:0] t [4];
        for (int i = 0; i < LANES; i++)
        begin
            case (kind)
                0: write_reg(IDXW'(i), RW'($urandom_range(1, 65535)));
                1: write_reg(IDXW'(i), R_MAX);
                2: write_reg(IDXW'(i), RW'($urandom_range(0, 3)));
                default: write_reg(IDXW'(i), RW'($urandom_range(100, 5000)));
            endcase
        end
        for (int i = 0; i < 4; i++)
            t[i] = RW'($urandom_range(0, 65535));
        if (kind != 1)
            t.rsort();
        write_reg(IDX_DARK, t[0]);
        write_reg(IDX_INDOOR, t[1]);
        write_reg(IDX_SHADE, t[2]);
        write_reg(IDX_SUN, t[3]);
        write_reg(4'd12, RW'($urandom_range(0, 65535)));
    endtask

    sample_row_t directed [] = '{
        '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, '{LVL_FSUN, 16'd0, 1'b0}},
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, '{LVL_NIGHT, 16'hFFFF, 1'b1}},
        '{12'd4095, 12'd0,    12'd0,    12'd0,    1'b1, '{LVL_NIGHT, 16'd16383, 1'b1}},
        '{12'd0,    12'd4095, 12'd0,    12'd0,    1'b1, '{LVL_NIGHT, 16'd16383, 1'b1}},
        '{12'd0,    12'd0,    12'd4095, 12'd0,    1'b1, '{LVL_NIGHT, 16'd16383, 1'b1}},
        '{12'd0,    12'd0,    12'd0,    12'd4095, 1'b1, '{LVL_NIGHT, 16'd16383, 1'b1}},
        '{12'd4094, 12'd4094, 12'd4094, 12'd4094, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd1,    12'd1,    12'd1,    12'd1,    1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd2730, 12'd2730, 12'd2730, 12'd2730, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd3900, 12'd3900, 12'd3900, 12'd3900, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd800,  12'd800,  12'd800,  12'd800,  1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd400,  12'd400,  12'd400,  12'd400,  1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'd3000, 12'd100,  12'd2000, 12'd4000, 1'b0, '{3'd0, 16'd0, 1'b0}},
        '{12'hAAA,  12'h555,  12'hAAA,  12'h555,  1'b0, '{3'd0, 16'd0, 1'b0}}
    };

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (long_hold)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (sink_idle_enable && $urandom_range(0, 9) == 0)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ldrc_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected item: level %0d avg %0d sat %0d",
                             out_ch.light_level, out_ch.avg_resistance, out_ch.saturated);
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_ch.light_level !== e.level || out_ch.avg_resistance !== e.avg
                    || out_ch.saturated !== e.sat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected level %0d avg %0d sat %0d, got %0d %0d %0d",
                                 e.level, e.avg, e.sat, out_ch.light_level,
                                 out_ch.avg_resistance, out_ch.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready) || finished)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int hold_len;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample_ch0 = '0;
        in_ch.sample_ch1 = '0;
        in_ch.sample_ch2 = '0;
        in_ch.sample_ch3 = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        sink_idle_enable = 1'b1;
        long_hold = 1'b0;
        finished = 1'b0;
        for (int i = 0; i < LANES; i++)
            divider_ohms[i] = 16'd490;
        thr_dark = 16'd10000;
        thr_indoor = 16'd1000;
        thr_shade = 16'd300;
        thr_sun = 16'd100;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_set(directed[i].s0, directed[i].s1, directed[i].s2, directed[i].s3,
                     directed[i].known, directed[i].res);
        end_burst();
        wait_drained();

        // A zero divider resistor and thresholds out of order.
        write_reg(IDX_DIVR0, 16'd0);
        write_reg(IDX_DIVR1, R_MAX);
        write_reg(IDX_DIVR2, 16'd1);
        write_reg(IDX_DIVR3, 16'd490);
        write_reg(IDX_DARK, 16'd0);
        write_reg(IDX_INDOOR, R_MAX);
        write_reg(IDX_SHADE, 16'd50);
        write_reg(IDX_SUN, R_MAX);
        for (int i = 0; i < 6; i++)
            send_set(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b0, '0);
        end_burst();
        wait_drained();
        write_reg(IDX_DARK, R_MAX);
        write_reg(IDX_INDOOR, R_MAX);
        write_reg(IDX_SHADE, R_MAX);
        write_reg(IDX_SUN, R_MAX);
        send_set(12'd10, 12'd4094, 12'd4000, 12'd3000, 1'b0, '0);
        end_burst();
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            random_config(phase % 4);
            if (phase == 2)
            begin
                hold_len = 200;
                long_hold = 1'b1;
                fork
                    begin
                        repeat (hold_len) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            sink_idle_enable = (phase < 6);
            for (int n = 0; n < 235; n++)
            begin
                if (phase >= 6)
                begin
                    in_ch.valid      <= 1'b1;
                    in_ch.sample_ch0 <= rand_sample();
                    in_ch.sample_ch1 <= rand_sample();
                    in_ch.sample_ch2 <= rand_sample();
                    in_ch.sample_ch3 <= rand_sample();
                    @(negedge clk);
                    expected_results.push_back(classify(in_ch.sample_ch0, in_ch.sample_ch1,
                                                        in_ch.sample_ch2, in_ch.sample_ch3));
                    do
                        @(posedge clk);
                    while (!in_ch.ready);
                end
                else
                begin
                    send_set(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                             1'b0, '0);
                end
            end
            end_burst();
            wait_drained();
        end

        finished = 1'b1;
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
